[src/csbc_pkg.sv]
// Package for the clock set-button controller: field widths, codes,
// configuration, state and beat structures, and the day-clamp function.
// Depends on nothing; every other file of the block uses it.
package csbc_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 12;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned FieldW  = 3;
  localparam int unsigned TickW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // Calendar limits
  localparam logic [HourW:0]    HourMax   = 6'd23;
  localparam logic [MinuteW:0]  MinuteMax = 7'd59;
  localparam logic [MonthW:0]   MonthMax  = 5'd12;
  localparam logic [WdayW:0]    WdayMax   = 4'd6;
  localparam logic [TickW-1:0]  TickSat   = 8'd255;

  // Configuration reset values
  localparam logic [TimeW-1:0] DebounceReset = 32'd250000;
  localparam logic [YearW-1:0] YearFirstReset = 12'd2020;
  localparam logic [YearW-1:0] YearLastReset  = 12'd2050;
  localparam logic [TickW-1:0] IdleLimitReset = 8'd5;

  // Event kinds
  localparam logic MODE_BUTTON = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Field selected for editing
  typedef enum logic [FieldW-1:0] {
    FIELD_COLON   = 3'd0,
    FIELD_HOUR    = 3'd1,
    FIELD_MINUTE  = 3'd2,
    FIELD_DAY     = 3'd3,
    FIELD_MONTH   = 3'd4,
    FIELD_YEAR    = 3'd5,
    FIELD_WEEKDAY = 3'd6
  } field_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_YEAR_FIRST = 2'd1,
    CFG_YEAR_LAST  = 2'd2,
    CFG_IDLE_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TimeW-1:0] debounce_window_us;
    logic [YearW-1:0] year_first;
    logic [YearW-1:0] year_last;
    logic [TickW-1:0] idle_tick_limit;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] last_event_time;
    logic             set_mode;
    field_t           selected_field;
    logic [TickW-1:0] idle_ticks;
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [TimeW-1:0]   time_us;
    logic               set_pressed;
    logic               up_pressed;
    logic [HourW-1:0]   cur_hour;
    logic [MinuteW-1:0] cur_minute;
    logic [DayW-1:0]    cur_day;
    logic [MonthW-1:0]  cur_month;
    logic [YearW-1:0]   cur_year;
    logic [WdayW-1:0]   cur_weekday;
  } event_t;

  typedef struct packed {
    logic               write_time;
    logic [HourW-1:0]   new_hour;
    logic [MinuteW-1:0] new_minute;
    logic [DayW-1:0]    new_day;
    logic [MonthW-1:0]  new_month;
    logic [YearW-1:0]   new_year;
    logic [WdayW-1:0]   new_weekday;
    logic [FieldW-1:0]  blink_field;
    logic               setting_active;
  } result_t;

  // Day past the end of the month becomes the first; unknown months have 30 days
  function automatic logic [DayW-1:0] clamp_day(input logic [DayW:0]    day,
                                                input logic [MonthW-1:0] month,
                                                input logic [YearW-1:0]  year);
    logic [DayW:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
      4'd2: len = (year[1:0] == 2'b00) ? 6'd29 : 6'd28;
      default: len = 6'd30;
    endcase
    clamp_day = (day > len) ? DayW'(1) : day[DayW-1:0];
  endfunction

endpackage

[src/csbc_if.sv]
// Handshake channels of the clock set-button controller: event input and result output.
// Depends on csbc_pkg for field widths.
interface csbc_evt_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [csbc_pkg::TimeW-1:0]         time_us;
  logic                               set_pressed;
  logic                               up_pressed;
  logic [csbc_pkg::HourW-1:0]         cur_hour;
  logic [csbc_pkg::MinuteW-1:0]       cur_minute;
  logic [csbc_pkg::DayW-1:0]          cur_day;
  logic [csbc_pkg::MonthW-1:0]        cur_month;
  logic [csbc_pkg::YearW-1:0]         cur_year;
  logic [csbc_pkg::WdayW-1:0]         cur_weekday;

  modport source (
    output valid, mode, time_us, set_pressed, up_pressed, cur_hour, cur_minute,
           cur_day, cur_month, cur_year, cur_weekday,
    input  ready
  );
  modport sink (
    input  valid, mode, time_us, set_pressed, up_pressed, cur_hour, cur_minute,
           cur_day, cur_month, cur_year, cur_weekday,
    output ready
  );
endinterface

interface csbc_res_if;
  logic                               valid;
  logic                               ready;
  logic                               write_time;
  logic [csbc_pkg::HourW-1:0]         new_hour;
  logic [csbc_pkg::MinuteW-1:0]       new_minute;
  logic [csbc_pkg::DayW-1:0]          new_day;
  logic [csbc_pkg::MonthW-1:0]        new_month;
  logic [csbc_pkg::YearW-1:0]         new_year;
  logic [csbc_pkg::WdayW-1:0]         new_weekday;
  logic [csbc_pkg::FieldW-1:0]        blink_field;
  logic                               setting_active;

  modport source (
    output valid, write_time, new_hour, new_minute, new_day, new_month, new_year,
           new_weekday, blink_field, setting_active,
    input  ready
  );
  modport sink (
    input  valid, write_time, new_hour, new_minute, new_day, new_month, new_year,
           new_weekday, blink_field, setting_active,
    output ready
  );
endinterface

[src/csbc_cfg_regs.sv]
// Configuration registers of the clock set-button controller.
// Depends on csbc_pkg for the register indexes and the cfg_t structure.
module csbc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [csbc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csbc_pkg::CfgDataW-1:0]  cfg_data,
  output csbc_pkg::cfg_t                 cfg
);

  // Load the addressed register, truncated to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_window_us <= csbc_pkg::DebounceReset;
      cfg.year_first         <= csbc_pkg::YearFirstReset;
      cfg.year_last          <= csbc_pkg::YearLastReset;
      cfg.idle_tick_limit    <= csbc_pkg::IdleLimitReset;
    end else if (cfg_wr_en) begin
      case (csbc_pkg::cfg_idx_t'(cfg_index))
        csbc_pkg::CFG_DEBOUNCE:
          cfg.debounce_window_us <= cfg_data[csbc_pkg::TimeW-1:0];
        csbc_pkg::CFG_YEAR_FIRST:
          cfg.year_first <= cfg_data[csbc_pkg::YearW-1:0];
        csbc_pkg::CFG_YEAR_LAST:
          cfg.year_last <= cfg_data[csbc_pkg::YearW-1:0];
        csbc_pkg::CFG_IDLE_LIMIT:
          cfg.idle_tick_limit <= cfg_data[csbc_pkg::TickW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[src/csbc_update.sv]
// Next-state and result logic for one event of the clock set-button controller.
// Purely combinational; depends on csbc_pkg for structures and clamp_day.
module csbc_update (
  input  csbc_pkg::cfg_t    cfg,
  input  csbc_pkg::state_t  state,
  input  csbc_pkg::event_t  evt,
  output csbc_pkg::state_t  state_next,
  output csbc_pkg::result_t res
);

  logic [csbc_pkg::TimeW-1:0]   gap;
  logic [csbc_pkg::TickW-1:0]   ticks_inc;
  logic [csbc_pkg::FieldW-1:0]  field_inc;
  logic [csbc_pkg::HourW:0]     hour_inc;
  logic [csbc_pkg::MinuteW:0]   minute_inc;
  logic [csbc_pkg::DayW:0]      day_inc;
  logic [csbc_pkg::MonthW:0]    month_inc;
  logic [csbc_pkg::MonthW-1:0]  month_new;
  logic [csbc_pkg::YearW:0]     year_inc;
  logic [csbc_pkg::YearW-1:0]   year_new;
  logic [csbc_pkg::WdayW:0]     wday_inc;

  // Increments of each field and of the counters
  assign gap        = evt.time_us - state.last_event_time;
  assign ticks_inc  = (state.idle_ticks == csbc_pkg::TickSat) ? state.idle_ticks
                                                              : state.idle_ticks + 1'b1;
  assign field_inc  = state.selected_field + 1'b1;
  assign hour_inc   = {1'b0, evt.cur_hour} + 1'b1;
  assign minute_inc = {1'b0, evt.cur_minute} + 1'b1;
  assign day_inc    = {1'b0, evt.cur_day} + 1'b1;
  assign month_inc  = {1'b0, evt.cur_month} + 1'b1;
  assign month_new  = (month_inc > csbc_pkg::MonthMax) ? csbc_pkg::MonthW'(1)
                                                       : month_inc[csbc_pkg::MonthW-1:0];
  assign year_inc   = {1'b0, evt.cur_year} + 1'b1;
  assign year_new   = (year_inc > {1'b0, cfg.year_last}) ? cfg.year_first
                                                         : year_inc[csbc_pkg::YearW-1:0];
  assign wday_inc   = {1'b0, evt.cur_weekday} + 1'b1;

  // Apply tick or button event
  always_comb begin
    state_next         = state;
    res.write_time     = 1'b0;
    res.new_hour       = evt.cur_hour;
    res.new_minute     = evt.cur_minute;
    res.new_day        = evt.cur_day;
    res.new_month      = evt.cur_month;
    res.new_year       = evt.cur_year;
    res.new_weekday    = evt.cur_weekday;

    if (evt.mode == csbc_pkg::MODE_TICK) begin
      // Count idle seconds in set mode, drop out at the limit
      if (state.set_mode) begin
        state_next.idle_ticks = ticks_inc;
        if (ticks_inc >= cfg.idle_tick_limit) begin
          state_next.set_mode       = 1'b0;
          state_next.idle_ticks     = '0;
          state_next.selected_field = csbc_pkg::FIELD_COLON;
        end
      end
    end else begin
      if (gap > cfg.debounce_window_us) begin
        // Set button: step to the next field, leave after weekday
        if (evt.set_pressed) begin
          state_next.idle_ticks = '0;
          if (field_inc == 3'd7 || field_inc == csbc_pkg::FIELD_COLON) begin
            state_next.set_mode       = 1'b0;
            state_next.selected_field = csbc_pkg::FIELD_COLON;
          end else begin
            state_next.set_mode       = 1'b1;
            state_next.selected_field = csbc_pkg::field_t'(field_inc);
          end
        end
        // Up button: bump the selected field of the current time
        if (evt.up_pressed) begin
          state_next.idle_ticks = '0;
          if (state_next.set_mode) begin
            res.write_time = 1'b1;
            case (state_next.selected_field)
              csbc_pkg::FIELD_HOUR:
                res.new_hour = (hour_inc > csbc_pkg::HourMax) ? '0
                                                              : hour_inc[csbc_pkg::HourW-1:0];
              csbc_pkg::FIELD_MINUTE:
                res.new_minute = (minute_inc > csbc_pkg::MinuteMax) ? '0
                                 : minute_inc[csbc_pkg::MinuteW-1:0];
              csbc_pkg::FIELD_DAY:
                res.new_day = csbc_pkg::clamp_day(day_inc, evt.cur_month, evt.cur_year);
              csbc_pkg::FIELD_MONTH: begin
                res.new_month = month_new;
                res.new_day   = csbc_pkg::clamp_day({1'b0, evt.cur_day}, month_new,
                                                    evt.cur_year);
              end
              csbc_pkg::FIELD_YEAR: begin
                res.new_year = year_new;
                res.new_day  = csbc_pkg::clamp_day({1'b0, evt.cur_day}, evt.cur_month,
                                                   year_new);
              end
              csbc_pkg::FIELD_WEEKDAY:
                res.new_weekday = (wday_inc > csbc_pkg::WdayMax) ? '0
                                                                 : wday_inc[csbc_pkg::WdayW-1:0];
              default:
                res.write_time = 1'b0;
            endcase
          end
        end
      end
      state_next.last_event_time = evt.time_us;
    end

    res.blink_field    = state_next.selected_field;
    res.setting_active = state_next.set_mode;
  end

endmodule

[src/clock_set_button_controller.sv]
// Clock set-button controller: debounced set/up buttons and idle ticks drive time setting.
// An accepted event beat moves from the input register through the combinational update
// logic into the result register, which holds while the sink stalls. One event per cycle
// while the sink does not stall; the state register follows each event.
// Reset (synchronous, active high) empties both registers, leaves set mode, clears the
// stored event time and idle count, and restores the configuration reset values.
module clock_set_button_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [csbc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csbc_pkg::CfgDataW-1:0]  cfg_data,
  csbc_evt_if.sink                       evt,
  csbc_res_if.source                     res
);

  csbc_pkg::cfg_t    cfg;
  csbc_pkg::state_t  state;
  csbc_pkg::state_t  state_next;
  csbc_pkg::event_t  evt_d;
  csbc_pkg::event_t  evt_q;
  csbc_pkg::result_t res_d;
  csbc_pkg::result_t res_q;
  logic              evt_valid;
  logic              res_valid;
  logic              res_load;
  logic              evt_load;

  csbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csbc_update u_update (
    .cfg        (cfg),
    .state      (state),
    .evt        (evt_q),
    .state_next (state_next),
    .res        (res_d)
  );

  // Gather the input beat
  assign evt_d = '{mode:        evt.mode,
                   time_us:     evt.time_us,
                   set_pressed: evt.set_pressed,
                   up_pressed:  evt.up_pressed,
                   cur_hour:    evt.cur_hour,
                   cur_minute:  evt.cur_minute,
                   cur_day:     evt.cur_day,
                   cur_month:   evt.cur_month,
                   cur_year:    evt.cur_year,
                   cur_weekday: evt.cur_weekday};

  // Advance when the next stage is empty or draining
  assign res_load  = evt_valid && (!res_valid || res.ready);
  assign evt.ready = !evt_valid || res_load;
  assign evt_load  = evt.valid && evt.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (evt.ready) begin
      evt_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_load) begin
      evt_q <= evt_d;
    end
  end

  // Controller state, updated as each event moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_event_time <= '0;
      state.set_mode        <= 1'b0;
      state.selected_field  <= csbc_pkg::FIELD_COLON;
      state.idle_ticks      <= '0;
    end else if (res_load) begin
      state <= state_next;
    end
  end

  // Result register; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res.valid          = res_valid;
  assign res.write_time     = res_q.write_time;
  assign res.new_hour       = res_q.new_hour;
  assign res.new_minute     = res_q.new_minute;
  assign res.new_day        = res_q.new_day;
  assign res.new_month      = res_q.new_month;
  assign res.new_year       = res_q.new_year;
  assign res.new_weekday    = res_q.new_weekday;
  assign res.blink_field    = res_q.blink_field;
  assign res.setting_active = res_q.setting_active;

`ifndef SYNTH
  // Set mode always has a real field selected
  assert property (@(posedge clk) disable iff (rst)
    state.set_mode |-> (state.selected_field != csbc_pkg::FIELD_COLON &&
                        state.selected_field != 3'd7))
    else $error("set mode with no editable field selected");

  // A time write only happens while setting
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.write_time) |-> res_q.setting_active)
    else $error("time write outside set mode");

  // Leaving set mode always returns the blink to the colon
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_q.setting_active) |->
      res_q.blink_field == csbc_pkg::FIELD_COLON)
    else $error("field still selected outside set mode");

  // An event leaving the input register shows up as a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid)
    else $error("result lost after input register advanced");
`endif

endmodule

[sim/clock_set_button_controller_tb.sv]
// Self-checking testbench for the clock set-button controller: button/tick events in,
// predicted set-mode and time-write results compared beat by beat at the output.
// Depends on csbc_pkg, the csbc_evt_if/csbc_res_if channels and the controller RTL.
module clock_set_button_controller_tb;

  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef enum logic [1:0] {
    ITEM_EVENT,
    ITEM_CFG,
    ITEM_DRAIN
  } item_kind_t;

  typedef struct packed {
    item_kind_t                    kind;
    csbc_pkg::event_t              ev;
    csbc_pkg::cfg_idx_t            idx;
    logic [csbc_pkg::CfgDataW-1:0] data;
  } stim_item_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [csbc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [csbc_pkg::CfgDataW-1:0] cfg_data;

  csbc_evt_if evt_ch ();
  csbc_res_if res_ch ();

  clock_set_button_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .res       (res_ch)
  );

  always #2 clk = ~clk;

  // Stimulus items still to send and results still to arrive
  stim_item_t        queued_beats[$];
  csbc_pkg::result_t awaited_results[$];

  // Predicted controller state and register file
  csbc_pkg::cfg_t                cfg_model;
  logic [csbc_pkg::TimeW-1:0]    last_button_us;
  logic                          editing;
  csbc_pkg::field_t              edit_field;
  logic [csbc_pkg::TickW-1:0]    idle_count;

  // Register values and last button time as the stimulus generator sees them
  csbc_pkg::cfg_t                planned_cfg;
  logic [csbc_pkg::TimeW-1:0]    gen_last_us;

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          event_beat_seen = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_calm = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic csbc_pkg::cfg_t cfg_apply(input csbc_pkg::cfg_t c,
                                               input csbc_pkg::cfg_idx_t idx,
                                               input logic [csbc_pkg::CfgDataW-1:0] data);
    case (idx)
      csbc_pkg::CFG_DEBOUNCE:   c.debounce_window_us = data;
      csbc_pkg::CFG_YEAR_FIRST: c.year_first = data[csbc_pkg::YearW-1:0];
      csbc_pkg::CFG_YEAR_LAST:  c.year_last = data[csbc_pkg::YearW-1:0];
      csbc_pkg::CFG_IDLE_LIMIT: c.idle_tick_limit = data[csbc_pkg::TickW-1:0];
      default: ;
    endcase
    cfg_apply = c;
  endfunction

  // Day past the month's last day folds back to the first
  function automatic logic [csbc_pkg::DayW-1:0] fit_day(
      input logic [csbc_pkg::DayW:0]    day,
      input logic [csbc_pkg::MonthW-1:0] month,
      input logic [csbc_pkg::YearW-1:0]  year);
    logic [csbc_pkg::DayW:0] last_day;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: last_day = 6'd31;
      4'd2: last_day = (year[1:0] == 2'b00) ? 6'd29 : 6'd28;
      default: last_day = 6'd30;
    endcase
    fit_day = (day > last_day) ? csbc_pkg::DayW'(1) : day[csbc_pkg::DayW-1:0];
  endfunction

  function automatic void leave_editing();
    editing = 1'b0;
    idle_count = '0;
    edit_field = csbc_pkg::FIELD_COLON;
  endfunction

  // Advance the predicted state by one event and return the result it causes
  function automatic csbc_pkg::result_t predict_time_update(input csbc_pkg::event_t ev);
    csbc_pkg::result_t          r;
    logic [csbc_pkg::TimeW-1:0] elapsed;
    logic [csbc_pkg::FieldW:0]  step;
    r.write_time  = 1'b0;
    r.new_hour    = ev.cur_hour;
    r.new_minute  = ev.cur_minute;
    r.new_day     = ev.cur_day;
    r.new_month   = ev.cur_month;
    r.new_year    = ev.cur_year;
    r.new_weekday = ev.cur_weekday;
    if (ev.mode == csbc_pkg::MODE_TICK) begin
      if (editing) begin
        if (idle_count != csbc_pkg::TickSat) idle_count = idle_count + 1'b1;
        if (idle_count >= cfg_model.idle_tick_limit) leave_editing();
      end
    end else begin
      elapsed = ev.time_us - last_button_us;
      if (elapsed > cfg_model.debounce_window_us) begin
        // Set steps the field first, so up sees the new selection
        if (ev.set_pressed) begin
          editing = 1'b1;
          idle_count = '0;
          step = {1'b0, edit_field} + 1'b1;
          if (step > csbc_pkg::FIELD_WEEKDAY) leave_editing();
          else edit_field = csbc_pkg::field_t'(step[csbc_pkg::FieldW-1:0]);
        end
        if (ev.up_pressed) begin
          idle_count = '0;
          if (editing) begin
            r.write_time = 1'b1;
            case (edit_field)
              csbc_pkg::FIELD_HOUR:
                r.new_hour = (ev.cur_hour >= csbc_pkg::HourMax) ? '0
                                                                : ev.cur_hour + 1'b1;
              csbc_pkg::FIELD_MINUTE:
                r.new_minute = (ev.cur_minute >= csbc_pkg::MinuteMax) ? '0
                                                                      : ev.cur_minute + 1'b1;
              csbc_pkg::FIELD_DAY:
                r.new_day = fit_day({1'b0, ev.cur_day} + 6'd1, ev.cur_month, ev.cur_year);
              csbc_pkg::FIELD_MONTH: begin
                r.new_month = (ev.cur_month >= csbc_pkg::MonthMax) ? csbc_pkg::MonthW'(1)
                                                                   : ev.cur_month + 1'b1;
                r.new_day = fit_day({1'b0, ev.cur_day}, r.new_month, ev.cur_year);
              end
              csbc_pkg::FIELD_YEAR: begin
                r.new_year = (({1'b0, ev.cur_year} + 13'd1) > {1'b0, cfg_model.year_last}) ?
                             cfg_model.year_first : ev.cur_year + 1'b1;
                r.new_day = fit_day({1'b0, ev.cur_day}, ev.cur_month, r.new_year);
              end
              csbc_pkg::FIELD_WEEKDAY:
                r.new_weekday = (ev.cur_weekday >= csbc_pkg::WdayMax) ? '0
                                                                      : ev.cur_weekday + 1'b1;
              default: r.write_time = 1'b0;
            endcase
          end
        end
      end
      last_button_us = ev.time_us;
    end
    r.blink_field    = edit_field;
    r.setting_active = editing;
    predict_time_update = r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Pause length: mostly none or short, a few long, with calm stretches of no pause
  function automatic int unsigned draw_pause(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      draw_pause = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm = $urandom_range(20, 80);
        draw_pause = 0;
      end else if (r < 55) draw_pause = 0;
      else if (r < 85) draw_pause = $urandom_range(1, 3);
      else if (r < 97) draw_pause = $urandom_range(4, 12);
      else draw_pause = $urandom_range(20, 60);
    end
  endfunction

  // Favor the top of the range, sometimes any value the field width allows
  function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
                                             input int unsigned bits);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) pick_value = hi;
    else if (r < 85) pick_value = $urandom_range(lo, hi);
    else pick_value = $urandom & ((32'd1 << bits) - 1);
  endfunction

  function automatic csbc_pkg::event_t random_calendar();
    csbc_pkg::event_t           ev;
    logic [95:0]                raw;
    logic [csbc_pkg::YearW-1:0] ylo;
    logic [csbc_pkg::YearW-1:0] yhi;
    raw = {$urandom, $urandom, $urandom};
    ev = raw[$bits(csbc_pkg::event_t)-1:0];
    ylo = (planned_cfg.year_first < planned_cfg.year_last) ?
          planned_cfg.year_first : planned_cfg.year_last;
    yhi = (planned_cfg.year_first < planned_cfg.year_last) ?
          planned_cfg.year_last : planned_cfg.year_first;
    ev.cur_hour    = csbc_pkg::HourW'(pick_value(0, 23, csbc_pkg::HourW));
    ev.cur_minute  = csbc_pkg::MinuteW'(pick_value(0, 59, csbc_pkg::MinuteW));
    ev.cur_day     = csbc_pkg::DayW'(pick_value(1, 31, csbc_pkg::DayW));
    ev.cur_month   = csbc_pkg::MonthW'(pick_value(1, 12, csbc_pkg::MonthW));
    ev.cur_year    = csbc_pkg::YearW'(pick_value(32'(ylo), 32'(yhi), csbc_pkg::YearW));
    ev.cur_weekday = csbc_pkg::WdayW'(pick_value(0, 6, csbc_pkg::WdayW));
    random_calendar = ev;
  endfunction

  task automatic queue_event(input csbc_pkg::event_t ev);
    stim_item_t item;
    item = '0;
    item.kind = ITEM_EVENT;
    item.ev = ev;
    queued_beats.push_back(item);
    if (ev.mode == csbc_pkg::MODE_BUTTON) gen_last_us = ev.time_us;
  endtask

  task automatic queue_write(input csbc_pkg::cfg_idx_t idx,
                             input logic [csbc_pkg::CfgDataW-1:0] data);
    stim_item_t item;
    item = '0;
    item.kind = ITEM_CFG;
    item.idx = idx;
    item.data = data;
    queued_beats.push_back(item);
    planned_cfg = cfg_apply(planned_cfg, idx, data);
  endtask

  task automatic queue_settings(input logic [csbc_pkg::CfgDataW-1:0] debounce,
                                input logic [csbc_pkg::CfgDataW-1:0] yfirst,
                                input logic [csbc_pkg::CfgDataW-1:0] ylast,
                                input logic [csbc_pkg::CfgDataW-1:0] limit);
    queue_write(csbc_pkg::CFG_DEBOUNCE, debounce);
    queue_write(csbc_pkg::CFG_YEAR_FIRST, yfirst);
    queue_write(csbc_pkg::CFG_YEAR_LAST, ylast);
    queue_write(csbc_pkg::CFG_IDLE_LIMIT, limit);
  endtask

  task automatic queue_drain();
    stim_item_t item;
    item = '0;
    item.kind = ITEM_DRAIN;
    queued_beats.push_back(item);
  endtask

  task automatic queue_press(input logic [csbc_pkg::TimeW-1:0] t,
                             input int unsigned set_p, input int unsigned up_p,
                             input int unsigned h, input int unsigned mi,
                             input int unsigned d, input int unsigned mo,
                             input int unsigned y, input int unsigned w);
    csbc_pkg::event_t ev;
    ev.mode        = csbc_pkg::MODE_BUTTON;
    ev.time_us     = t;
    ev.set_pressed = 1'(set_p);
    ev.up_pressed  = 1'(up_p);
    ev.cur_hour    = csbc_pkg::HourW'(h);
    ev.cur_minute  = csbc_pkg::MinuteW'(mi);
    ev.cur_day     = csbc_pkg::DayW'(d);
    ev.cur_month   = csbc_pkg::MonthW'(mo);
    ev.cur_year    = csbc_pkg::YearW'(y);
    ev.cur_weekday = csbc_pkg::WdayW'(w);
    queue_event(ev);
  endtask

  task automatic queue_tick();
    csbc_pkg::event_t ev;
    ev = random_calendar();
    ev.mode = csbc_pkg::MODE_TICK;
    queue_event(ev);
  endtask

  // Button event clear of the debounce window, or a bounce inside or around it
  task automatic queue_button(input logic set_p, input logic up_p, input logic bounce);
    csbc_pkg::event_t           ev;
    logic [csbc_pkg::TimeW-1:0] delta;
    int unsigned                r;
    ev = random_calendar();
    ev.mode = csbc_pkg::MODE_BUTTON;
    ev.set_pressed = set_p;
    ev.up_pressed = up_p;
    r = $urandom_range(0, 3);
    if (!bounce) delta = planned_cfg.debounce_window_us + 1 + $urandom_range(0, 5000);
    else if (r == 0) delta = planned_cfg.debounce_window_us;
    else if (r == 1) delta = $urandom;
    else delta = $urandom_range(0, planned_cfg.debounce_window_us);
    ev.time_us = gen_last_us + delta;
    queue_event(ev);
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 3) == 0) queue_tick();
    else queue_button(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
  endtask

  // Mostly edit sequences: set presses to pick a field, then up presses on it
  task automatic queue_session(input int unsigned n_items);
    int unsigned made;
    int unsigned r;
    int unsigned k;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        k = $urandom_range(1, 7);
        repeat (k) queue_button(1'b1, ($urandom_range(0, 7) == 0), 1'b0);
        made += k;
        k = $urandom_range(0, 4);
        repeat (k) begin
          if ($urandom_range(0, 7) == 0) queue_noise();
          else queue_button(1'b0, 1'b1, 1'b0);
        end
        made += k;
      end else if (r < 85) begin
        k = $urandom_range(1, (planned_cfg.idle_tick_limit < 7) ?
                              planned_cfg.idle_tick_limit + 1 : 7);
        repeat (k) queue_tick();
        made += k;
      end else begin
        queue_noise();
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Sample both channels at the rising edge: check results, predict accepted events
  always @(posedge clk) begin
    csbc_pkg::result_t want;
    csbc_pkg::event_t  seen;
    event_beat_seen = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no result expected");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("write_time", 32'(want.write_time), 32'(res_ch.write_time));
          check_field("new_hour", 32'(want.new_hour), 32'(res_ch.new_hour));
          check_field("new_minute", 32'(want.new_minute), 32'(res_ch.new_minute));
          check_field("new_day", 32'(want.new_day), 32'(res_ch.new_day));
          check_field("new_month", 32'(want.new_month), 32'(res_ch.new_month));
          check_field("new_year", 32'(want.new_year), 32'(res_ch.new_year));
          check_field("new_weekday", 32'(want.new_weekday), 32'(res_ch.new_weekday));
          check_field("blink_field", 32'(want.blink_field), 32'(res_ch.blink_field));
          check_field("setting_active", 32'(want.setting_active),
                      32'(res_ch.setting_active));
        end
      end
      if (evt_ch.valid && evt_ch.ready) begin
        event_beat_seen = 1'b1;
        seen.mode        = evt_ch.mode;
        seen.time_us     = evt_ch.time_us;
        seen.set_pressed = evt_ch.set_pressed;
        seen.up_pressed  = evt_ch.up_pressed;
        seen.cur_hour    = evt_ch.cur_hour;
        seen.cur_minute  = evt_ch.cur_minute;
        seen.cur_day     = evt_ch.cur_day;
        seen.cur_month   = evt_ch.cur_month;
        seen.cur_year    = evt_ch.cur_year;
        seen.cur_weekday = evt_ch.cur_weekday;
        awaited_results.push_back(predict_time_update(seen));
      end
      // Watchdog: count cycles with no beat on either side and no register write
      if (event_beat_seen || (res_ch.valid && res_ch.ready) || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("clock_set_button_controller_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Event driver: hold a beat until taken, then pause, then send the next item
  always @(negedge clk) begin
    stim_item_t item;
    logic       next_valid;
    logic       next_wr;
    next_valid = 1'b0;
    next_wr = 1'b0;
    if (rst) begin
      send_gap = 0;
    end else if (evt_ch.valid && !event_beat_seen) begin
      next_valid = 1'b1;
    end else if (send_gap != 0) begin
      send_gap--;
    end else if (queued_beats.size() != 0) begin
      item = queued_beats[0];
      case (item.kind)
        ITEM_EVENT: begin
          evt_ch.mode        <= item.ev.mode;
          evt_ch.time_us     <= item.ev.time_us;
          evt_ch.set_pressed <= item.ev.set_pressed;
          evt_ch.up_pressed  <= item.ev.up_pressed;
          evt_ch.cur_hour    <= item.ev.cur_hour;
          evt_ch.cur_minute  <= item.ev.cur_minute;
          evt_ch.cur_day     <= item.ev.cur_day;
          evt_ch.cur_month   <= item.ev.cur_month;
          evt_ch.cur_year    <= item.ev.cur_year;
          evt_ch.cur_weekday <= item.ev.cur_weekday;
          next_valid = 1'b1;
          void'(queued_beats.pop_front());
          send_gap = draw_pause(send_calm);
        end
        // Write a register only once every result is back
        ITEM_CFG: begin
          if (awaited_results.size() == 0) begin
            cfg_index <= item.idx;
            cfg_data  <= item.data;
            next_wr = 1'b1;
            cfg_model = cfg_apply(cfg_model, item.idx, item.data);
            void'(queued_beats.pop_front());
          end
        end
        ITEM_DRAIN: begin
          if (awaited_results.size() == 0) void'(queued_beats.pop_front());
        end
        default: void'(queued_beats.pop_front());
      endcase
    end
    evt_ch.valid <= next_valid;
    cfg_wr_en <= next_wr;
  end

  // Result sink: stall ready at random
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= (sink_hold == 0);
      if (sink_hold == 0) sink_hold = draw_pause(sink_calm);
      else sink_hold--;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = csbc_pkg::CFG_DEBOUNCE;
    cfg_data = '0;
    evt_ch.valid = 1'b0;
    evt_ch.mode = csbc_pkg::MODE_BUTTON;
    evt_ch.time_us = '0;
    evt_ch.set_pressed = 1'b0;
    evt_ch.up_pressed = 1'b0;
    evt_ch.cur_hour = '0;
    evt_ch.cur_minute = '0;
    evt_ch.cur_day = '0;
    evt_ch.cur_month = '0;
    evt_ch.cur_year = '0;
    evt_ch.cur_weekday = '0;
    res_ch.ready = 1'b0;

    cfg_model = {csbc_pkg::DebounceReset, csbc_pkg::YearFirstReset,
                 csbc_pkg::YearLastReset, csbc_pkg::IdleLimitReset};
    planned_cfg = cfg_model;
    last_button_us = '0;
    gen_last_us = '0;
    leave_editing();

    // Directed part under the reset register values
    queue_press(32'd100, 1, 0, 12, 30, 15, 6, 2030, 3);        // inside debounce window
    queue_tick();                                              // tick outside set mode
    queue_press(32'd1_000_000, 0, 1, 12, 30, 15, 6, 2030, 3);  // up outside set mode
    queue_press(32'd2_000_000, 1, 0, 12, 30, 15, 6, 2030, 3);  // enter set mode, hour
    queue_press(32'd3_000_000, 0, 1, 23, 30, 15, 6, 2030, 3);  // hour wraps
    queue_press(32'd4_000_000, 0, 1, 31, 30, 15, 6, 2030, 3);  // hour out of range
    queue_press(32'd5_000_000, 1, 1, 10, 59, 15, 6, 2030, 3);  // both: minute, wraps
    queue_press(32'd6_000_000, 1, 0, 10, 20, 15, 6, 2030, 3);  // day
    queue_press(32'd7_000_000, 0, 1, 10, 20, 31, 1, 2023, 3);  // day past month end
    queue_press(32'd8_000_000, 0, 1, 10, 20, 28, 2, 2024, 3);  // leap February
    queue_press(32'd9_000_000, 0, 1, 10, 20, 29, 2, 2023, 3);  // plain February
    queue_press(32'd10_000_000, 0, 1, 10, 20, 30, 15, 2023, 3); // unknown month
    queue_press(32'd11_000_000, 1, 0, 10, 20, 31, 1, 2023, 3); // month
    queue_press(32'd12_000_000, 0, 1, 10, 20, 31, 1, 2023, 3); // month shortens day
    queue_press(32'd13_000_000, 0, 1, 10, 20, 31, 12, 2023, 3); // month wraps
    queue_press(32'd14_000_000, 1, 0, 10, 20, 29, 2, 2050, 3); // year
    queue_press(32'd15_000_000, 0, 1, 10, 20, 29, 2, 2050, 3); // year wraps to first
    queue_press(32'd16_000_000, 0, 1, 10, 20, 29, 2, 2024, 3); // leap day lost
    queue_press(32'd17_000_000, 0, 1, 10, 20, 15, 6, 4095, 3); // year above last
    queue_press(32'd18_000_000, 1, 1, 10, 20, 15, 6, 2030, 6); // weekday wraps
    queue_press(32'hFFFF_0000, 1, 0, 10, 20, 15, 6, 2030, 7);  // leave set mode
    queue_press(32'h0010_0000, 1, 0, 10, 20, 15, 6, 2030, 0);  // time wraps past zero
    repeat (5) queue_tick();                                   // idle limit ends set mode
    queue_session(150);

    // Extremes: no debounce, full year span, shortest idle limit
    queue_settings(32'd0, 32'd0, 32'd4095, 32'd1);
    queue_session(75);
    queue_drain();
    queue_session(75);

    // Every button event filtered, reversed years, zero idle limit
    queue_settings(32'hFFFF_FFFF, 32'd4095, 32'd0, 32'd0);
    queue_session(60);

    // Longest idle limit: a long tick run, then a set press and a tick run past the limit
    queue_settings(32'd1000, 32'd2000, 32'd2099, 32'd255);
    repeat (256) queue_tick();
    queue_button(1'b1, 1'b0, 1'b0);
    repeat (256) queue_tick();
    queue_drain();
    queue_session(80);

    // Reversed year bounds
    queue_settings(32'd100, 32'd3000, 32'd2000, 32'd0);
    queue_session(75);
    queue_drain();
    queue_session(75);

    // Random register values
    queue_settings($urandom_range(0, 500_000), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(1, 255));
    queue_session(150);

    // Back to the reset values
    queue_settings(csbc_pkg::CfgDataW'(csbc_pkg::DebounceReset),
                   csbc_pkg::CfgDataW'(csbc_pkg::YearFirstReset),
                   csbc_pkg::CfgDataW'(csbc_pkg::YearLastReset),
                   csbc_pkg::CfgDataW'(csbc_pkg::IdleLimitReset));
    queue_session(150);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for all beats to go out and every result to come back
    while (queued_beats.size() != 0 || evt_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) $display("clock_set_button_controller_tb: clean");
    else $display("clock_set_button_controller_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
src/csbc_pkg.sv
src/csbc_if.sv
src/csbc_cfg_regs.sv
src/csbc_update.sv
src/clock_set_button_controller.sv
sim/clock_set_button_controller_tb.sv
